>>> sv/tgr_pkg.sv
`timescale 1ns / 1ps
package tgr_pkg;

   // Default build
   localparam int TGR_MAX_POINTERS = 10;
   localparam int TGR_COORD_BITS   = 20;
   localparam int TGR_TIME_BITS    = 32;

   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes and reset values
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_SLOP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DTAP_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LPRESS_TIME = 2'd2;
   localparam logic [15:0] SLOP_RESET   = 16'd128;
   localparam logic [15:0] WINDOW_RESET = 16'd300;
   localparam logic [15:0] LPRESS_RESET = 16'd500;

   // Q8.8 zoom factors
   localparam logic [15:0] ZOOM_ONE  = 16'd256;
   localparam logic [15:0] ZOOM_UP   = 16'd282;
   localparam logic [15:0] ZOOM_DOWN = 16'd230;

   localparam int MOD_SHIFT_BIT = 0;
   localparam int MOD_CTRL_BIT  = 1;

   // Gesture codes
   localparam logic [2:0] G_TAP     = 3'd0;
   localparam logic [2:0] G_DTAP    = 3'd1;
   localparam logic [2:0] G_LPRESS  = 3'd2;
   localparam logic [2:0] G_DRAG    = 3'd3;
   localparam logic [2:0] G_SCROLL  = 3'd4;
   localparam logic [2:0] G_FSCROLL = 3'd5;
   localparam logic [2:0] G_SCALE   = 3'd6;
   localparam logic [2:0] G_MENU    = 3'd7;

   // Event codes, same values as on the bus
   typedef enum logic [3:0] {
      OP_MDOWN   = 4'd0,
      OP_MMOVE   = 4'd1,
      OP_MUP     = 4'd2,
      OP_WHEEL   = 4'd3,
      OP_RDOWN   = 4'd4,
      OP_DSCALE  = 4'd5,
      OP_DSCROLL = 4'd6,
      OP_TDOWN   = 4'd7,
      OP_PDOWN   = 4'd8,
      OP_PUP     = 4'd9,
      OP_TMOVE   = 4'd10,
      OP_TUP     = 4'd11,
      OP_CANCEL  = 4'd12
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] cnt;
   } item_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQA,
      ST_SQB,
      ST_SUM,
      ST_ROOT,
      ST_DINIT,
      ST_DIV,
      ST_DONE
   } seq_state_type;

endpackage

>>> sv/touch_gesture_recognizer_core.sv
`timescale 1ns / 1ps
// Touch and mouse gesture recogniser.
// req_*: one event per transfer; tuser carries the event code, tdata the
//   time stamp, pointer count, two points, modifiers, wheel deltas and zoom.
// rsp_*: at most one gesture per event; tuser carries the gesture code.
// csr_*: register writes (touch slop, double tap window, long press time),
//   always ready; write only while no event is in flight.
// Events needing no distance go from the head of the queue straight to
//   the result register. Events with a distance first pass the difference,
//   squaring and sum steps and the bit-serial square root; a pinch move
//   then also runs the bit-serial ratio divider.
// One event is worked on at a time; a two-entry queue keeps req ready
//   while the sequencer is busy. Dropped events (unknown code or no point)
//   never enter the queue.
// Reset clears the queue, the gesture state and the result valid flag and
//   restores the register defaults.
// A stalled rsp holds its transfer; the sequencer then waits with its
//   next result and the queue fills before req_tready drops.
module touch_gesture_recognizer_core import tgr_pkg::*; #(
   parameter int MAX_POINTERS = TGR_MAX_POINTERS,
   parameter int COORD_BITS   = TGR_COORD_BITS,
   parameter int TIME_BITS    = TGR_TIME_BITS,
   localparam int IN_DW  = ((TIME_BITS + 28 + 6 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_DW = ((4 * COORD_BITS + 26 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // time_ms, point count, x_first, y_first, x_second, y_second,
   // modifier_keys, wheel_x, wheel_y, direct_zoom, zero fill
   input  logic [IN_DW-1:0]     req_tdata,
   input  logic [3:0]           req_tuser,  // cmd
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // point_x, point_y, zoom, scroll_dx, scroll_dy, modifiers_out, zero fill
   output logic [OUT_DW-1:0]    rsp_tdata,
   output logic [2:0]           rsp_tuser,  // gesture
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int ITEM_W = IN_DW + $bits(item_ctrl_type);

   logic              q_full, q_push, q_pop, q_valid;
   logic [ITEM_W-1:0] q_in, q_head;

   // Front: drop and classify
   tgr_front #(
      .MAX_POINTERS (MAX_POINTERS),
      .COORD_BITS   (COORD_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in)
   );

   tgr_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // Back: gesture state, distance and ratio units, result register
   tgr_back #(
      .COORD_BITS (COORD_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign csr_ready = 1'b1;

endmodule

>>> sv/tgr_front.sv
`timescale 1ns / 1ps
module tgr_front import tgr_pkg::*; #(
   parameter int MAX_POINTERS = TGR_MAX_POINTERS,
   parameter int COORD_BITS   = TGR_COORD_BITS,
   parameter int TIME_BITS    = TGR_TIME_BITS,
   localparam int IN_DW  = ((TIME_BITS + 28 + 6 * COORD_BITS + 7) / 8) * 8,
   localparam int ITEM_W = IN_DW + $bits(item_ctrl_type)
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_DW-1:0]  req_tdata,
   input  logic [3:0]        req_tuser,
   input  logic              q_full,
   output logic              q_push,
   output logic [ITEM_W-1:0] q_item
);

   logic [3:0]    cnt_raw;
   logic [3:0]    cnt_cap;
   logic          cmd_known;
   logic          no_point_ok;
   logic          keep;
   item_ctrl_type ctrl;

   assign cnt_raw = req_tdata[TIME_BITS +: 4];
   assign cnt_cap = (cnt_raw > 4'(MAX_POINTERS)) ? 4'(MAX_POINTERS) : cnt_raw;

   // Unknown codes and pointer-less touch/mouse events are dropped here
   assign cmd_known   = (req_tuser <= 4'(OP_CANCEL));
   assign ctrl.op     = cmd_known ? op_type'(req_tuser) : OP_CANCEL;
   assign ctrl.cnt    = cnt_cap;
   assign no_point_ok = (ctrl.op == OP_WHEEL) || (ctrl.op == OP_DSCALE) ||
                        (ctrl.op == OP_DSCROLL) || (ctrl.op == OP_CANCEL);
   assign keep        = cmd_known && ((cnt_cap != 4'd0) || no_point_ok);

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;
   assign q_item     = {ctrl, req_tdata};

endmodule

>>> sv/tgr_queue.sv
`timescale 1ns / 1ps
module tgr_queue import tgr_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wptr_ff, rptr_ff;
   logic [CW-1:0]     count_ff;

   assign full  = (count_ff == CW'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/tgr_back.sv
`timescale 1ns / 1ps
module tgr_back import tgr_pkg::*; #(
   parameter int COORD_BITS = TGR_COORD_BITS,
   parameter int TIME_BITS  = TGR_TIME_BITS,
   localparam int IN_DW  = ((TIME_BITS + 28 + 6 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_DW = ((4 * COORD_BITS + 26 + 7) / 8) * 8,
   localparam int ITEM_W = IN_DW + $bits(item_ctrl_type)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  logic [ITEM_W-1:0]    q_item,
   output logic                 q_pop,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [OUT_DW-1:0]    rsp_tdata,
   output logic [2:0]           rsp_tuser
);

   localparam int W  = COORD_BITS;
   localparam int T  = TIME_BITS;
   localparam int OFF_X0 = T + 4;
   localparam int OFF_Y0 = OFF_X0 + W;
   localparam int OFF_X1 = OFF_Y0 + W;
   localparam int OFF_Y1 = OFF_X1 + W;
   localparam int OFF_MD = OFF_Y1 + W;
   localparam int OFF_WX = OFF_MD + 8;
   localparam int OFF_WY = OFF_WX + W;
   localparam int OFF_DZ = OFF_WY + W;
   localparam int SW  = 2 * W + 3;
   localparam int QW  = (2 * W + 2 > 64) ? 64 : 2 * W + 2;
   localparam int RW  = QW / 2;
   localparam int DW  = (RW > 16) ? RW : 16;
   localparam int NW  = W + 10;
   localparam int ITW = $clog2(NW);

   // ---- item fields
   item_ctrl_type         ctrl;
   logic [T-1:0]          now;
   logic [3:0]            cnt;
   logic signed [W-1:0]   x0, y0, x1, y1, wx, wy;
   logic [7:0]            mods;
   logic [15:0]           dz;

   assign ctrl = item_ctrl_type'(q_item[IN_DW +: $bits(item_ctrl_type)]);
   assign cnt  = ctrl.cnt;
   assign now  = q_item[0 +: T];
   assign x0   = q_item[OFF_X0 +: W];
   assign y0   = q_item[OFF_Y0 +: W];
   assign x1   = q_item[OFF_X1 +: W];
   assign y1   = q_item[OFF_Y1 +: W];
   assign mods = q_item[OFF_MD +: 8];
   assign wx   = q_item[OFF_WX +: W];
   assign wy   = q_item[OFF_WY +: W];
   assign dz   = q_item[OFF_DZ +: 16];

   // ---- configuration
   logic [15:0] slop_ff, window_ff, lpress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff   <= SLOP_RESET;
         window_ff <= WINDOW_RESET;
         lpress_ff <= LPRESS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOUCH_SLOP:  slop_ff   <= csr_data;
            CSR_DTAP_WINDOW: window_ff <= csr_data;
            CSR_LPRESS_TIME: lpress_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- gesture state
   logic              tap_pending_ff, tap_pending_in;
   logic              button_held_ff, button_held_in;
   logic              drag_active_ff, drag_active_in;
   logic              scroll_active_ff, scroll_active_in;
   logic              tap_recorded_ff, tap_recorded_in;
   logic [3:0]        down_points_ff, down_points_in;
   logic [3:0]        pmc_ff, pmc_in;
   logic signed [W-1:0] down_x_ff, down_x_in, down_y_ff, down_y_in;
   logic signed [W-1:0] move_x_ff, move_x_in, move_y_ff, move_y_in;
   logic signed [W-1:0] tap_x_ff, tap_x_in, tap_y_ff, tap_y_in;
   logic signed [W-1:0] px0_ff, px0_in, py0_ff, py0_in;
   logic signed [W-1:0] px1_ff, px1_in, py1_ff, py1_in;
   logic [T-1:0]      down_stamp_ff, down_stamp_in, tap_stamp_ff, tap_stamp_in;
   logic [W:0]        pinch_ff, pinch_in;

   // ---- distance operand selection
   logic                need_dist, need_div;
   logic signed [W-1:0] op_ax, op_ay, op_bx, op_by;

   always_comb begin
      need_dist = 1'b0;
      op_ax = x0;
      op_ay = y0;
      op_bx = x1;
      op_by = y1;
      unique case (ctrl.op)
         OP_MDOWN: begin
            need_dist = 1'b1;
            op_bx = tap_x_ff;
            op_by = tap_y_ff;
         end
         OP_MMOVE: begin
            need_dist = 1'b1;
            op_bx = move_x_ff;
            op_by = move_y_ff;
         end
         OP_PDOWN: begin
            need_dist = (cnt > 4'd1);
         end
         OP_TMOVE: begin
            need_dist = (down_points_ff == 4'd1) || (cnt == 4'd2);
            if (down_points_ff == 4'd1) begin
               op_bx = move_x_ff;
               op_by = move_y_ff;
            end
         end
         OP_TUP: begin
            need_dist = 1'b1;
            op_ax = down_x_ff;
            op_ay = down_y_ff;
            op_bx = tap_x_ff;
            op_by = tap_y_ff;
         end
         default: ;
      endcase
   end

   assign need_div = (ctrl.op == OP_TMOVE) && (down_points_ff != 4'd1) &&
                     (cnt == 4'd2) && (pinch_ff != '0);

   // ---- sequencer
   seq_state_type state_ff, state_in;
   logic [ITW-1:0] iter_ff;
   logic           commit;
   logic           res_valid;
   logic           out_free;

   assign out_free = !rsp_tvalid || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) begin
                      state_in = need_dist ? ST_DIFF : ST_DONE;
                   end
         ST_DIFF:  state_in = ST_SQA;
         ST_SQA:   state_in = ST_SQB;
         ST_SQB:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ROOT;
         ST_ROOT:  if (iter_ff == '0) begin
                      state_in = need_div ? ST_DINIT : ST_DONE;
                   end
         ST_DINIT: state_in = ST_DIV;
         ST_DIV:   if (iter_ff == '0) begin
                      state_in = ST_DONE;
                   end
         ST_DONE:  if (commit) begin
                      state_in = ST_IDLE;
                   end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      commit = (state_ff == ST_DONE) && (!res_valid || out_free);
      q_pop  = commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SUM) begin
            iter_ff <= ITW'(RW - 1);
         end else if (state_ff == ST_DINIT) begin
            iter_ff <= ITW'(NW - 1);
         end else if ((state_ff == ST_ROOT) || (state_ff == ST_DIV)) begin
            iter_ff <= iter_ff - 1'b1;
         end
      end
   end

   // ---- distance: one shared squarer, then one root bit per cycle
   logic signed [W:0]     dx_ff, dy_ff, mul_op;
   logic signed [2*W+1:0] prod;
   logic [2*W+1:0]        sqa_ff, sqb_ff;
   logic [SW-1:0]         sq_sum;
   logic [QW-1:0]         rad_in, rad_ff;
   logic [RW+1:0]         rem_ff;
   logic [RW-1:0]         root_ff;
   logic [RW+3:0]         rt_rem, rt_trial;
   logic                  rt_ge;

   assign mul_op   = (state_ff == ST_SQA) ? dx_ff : dy_ff;
   assign prod     = mul_op * mul_op;
   assign sq_sum   = SW'(sqa_ff) + SW'(sqb_ff);
   assign rad_in   = (|sq_sum[SW-1:QW]) ? '1 : sq_sum[QW-1:0];
   assign rt_rem   = {rem_ff, rad_ff[QW-1 -: 2]};
   assign rt_trial = {2'b00, root_ff, 2'b01};
   assign rt_ge    = (rt_rem >= rt_trial);

   // ---- pinch ratio: restoring divider, one quotient bit per cycle
   logic [NW-1:0] num_ff, quo_ff;
   logic [W+1:0]  drem_ff;
   logic [W+2:0]  dv_r2, dv_div;
   logic          dv_ge;
   logic [W:0]    root_w;
   logic [15:0]   zq;

   assign root_w = (W+1)'(root_ff);
   assign dv_r2  = {drem_ff, num_ff[NW-1]};
   assign dv_div = (W+3)'(pinch_ff);
   assign dv_ge  = (dv_r2 >= dv_div);
   assign zq     = (|quo_ff[NW-1:16]) ? 16'hFFFF : quo_ff[15:0];

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_DIFF: begin
            dx_ff <= (W+1)'(op_ax) - (W+1)'(op_bx);
            dy_ff <= (W+1)'(op_ay) - (W+1)'(op_by);
         end
         ST_SQA: sqa_ff <= prod;
         ST_SQB: sqb_ff <= prod;
         ST_SUM: begin
            rad_ff  <= rad_in;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         ST_ROOT: begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= rt_ge ? (RW+2)'(rt_rem - rt_trial) : rt_rem[RW+1:0];
            root_ff <= {root_ff[RW-2:0], rt_ge};
         end
         ST_DINIT: begin
            num_ff  <= NW'({root_w, 8'h00}) + NW'(pinch_ff >> 1);
            drem_ff <= '0;
            quo_ff  <= '0;
         end
         ST_DIV: begin
            num_ff  <= num_ff << 1;
            drem_ff <= dv_ge ? (W+2)'(dv_r2 - dv_div) : dv_r2[W+1:0];
            quo_ff  <= {quo_ff[NW-2:0], dv_ge};
         end
         default: ;
      endcase
   end

   // ---- decision on the finished item
   logic [DW-1:0]       dist_ext, slop_ext;
   logic                near, far;
   logic [T-1:0]        dt_tap, dt_down, dt_tapdown, win_ext, lp_ext;
   logic signed [W+1:0] sx, sy;
   logic [W+1:0]        ax, ay, axp, ayp;
   logic [W:0]          hx, hy;
   logic [2:0]          res_gesture;
   logic signed [W-1:0] res_px, res_py;
   logic [15:0]         res_zoom;
   logic [W:0]          res_dx, res_dy;
   logic [7:0]          res_mods;

   assign dist_ext   = DW'(root_ff);
   assign slop_ext   = DW'(slop_ff);
   assign near       = (dist_ext < slop_ext);
   assign far        = (dist_ext > slop_ext);
   assign dt_tap     = now - tap_stamp_ff;
   assign dt_down    = now - down_stamp_ff;
   assign dt_tapdown = down_stamp_ff - tap_stamp_ff;
   assign win_ext    = T'(window_ff);
   assign lp_ext     = T'(lpress_ff);

   assign sx  = (W+2)'(x0) - (W+2)'(px0_ff) + (W+2)'(x1) - (W+2)'(px1_ff);
   assign sy  = (W+2)'(y0) - (W+2)'(py0_ff) + (W+2)'(y1) - (W+2)'(py1_ff);
   assign ax  = sx[W+1] ? (W+2)'(-sx) : sx;
   assign ay  = sy[W+1] ? (W+2)'(-sy) : sy;
   assign axp = ax + 1'b1;
   assign ayp = ay + 1'b1;
   assign hx  = axp[W+1:1];
   assign hy  = ayp[W+1:1];

   always_comb begin
      tap_pending_in   = tap_pending_ff;
      button_held_in   = button_held_ff;
      drag_active_in   = drag_active_ff;
      scroll_active_in = scroll_active_ff;
      tap_recorded_in  = tap_recorded_ff;
      down_points_in   = down_points_ff;
      pmc_in           = pmc_ff;
      down_x_in        = down_x_ff;
      down_y_in        = down_y_ff;
      move_x_in        = move_x_ff;
      move_y_in        = move_y_ff;
      tap_x_in         = tap_x_ff;
      tap_y_in         = tap_y_ff;
      px0_in           = px0_ff;
      py0_in           = py0_ff;
      px1_in           = px1_ff;
      py1_in           = py1_ff;
      down_stamp_in    = down_stamp_ff;
      tap_stamp_in     = tap_stamp_ff;
      pinch_in         = pinch_ff;
      res_valid   = 1'b0;
      res_gesture = G_TAP;
      res_px      = '0;
      res_py      = '0;
      res_zoom    = ZOOM_ONE;
      res_dx      = '0;
      res_dy      = '0;
      res_mods    = '0;
      unique case (ctrl.op)
         OP_MDOWN: begin
            down_points_in = cnt;
            down_x_in      = x0;
            down_y_in      = y0;
            button_held_in = 1'b1;
            drag_active_in = 1'b0;
            move_x_in      = x0;
            move_y_in      = y0;
            down_stamp_in  = now;
            res_valid      = 1'b1;
            res_px         = x0;
            res_py         = y0;
            res_mods       = mods;
            if (tap_recorded_ff && (dt_tap <= win_ext) && near) begin
               tap_pending_in  = 1'b0;
               tap_recorded_in = 1'b0;
               res_gesture     = G_DTAP;
            end else begin
               tap_stamp_in    = now;
               tap_x_in        = x0;
               tap_y_in        = y0;
               tap_recorded_in = 1'b1;
               tap_pending_in  = 1'b1;
               res_gesture     = G_TAP;
            end
         end
         OP_MMOVE: begin
            if (button_held_ff && (far || drag_active_ff)) begin
               tap_pending_in = 1'b0;
               drag_active_in = 1'b1;
               move_x_in      = x0;
               move_y_in      = y0;
               res_valid      = 1'b1;
               res_gesture    = G_DRAG;
               res_px         = x0;
               res_py         = y0;
               res_mods       = mods;
            end
         end
         OP_MUP: begin
            button_held_in = 1'b0;
            drag_active_in = 1'b0;
         end
         OP_WHEEL: begin
            res_valid = 1'b1;
            res_mods  = mods;
            if (mods[MOD_CTRL_BIT]) begin
               res_gesture = G_SCALE;
               res_zoom    = (!wy[W-1] && (|wy)) ? ZOOM_UP : ZOOM_DOWN;
            end else if (mods[MOD_SHIFT_BIT]) begin
               res_gesture = G_SCROLL;
               res_dx      = (W+1)'(0) - (W+1)'(wy);
            end else begin
               res_gesture = G_SCROLL;
               res_dx      = (W+1)'(0) - (W+1)'(wx);
               res_dy      = (W+1)'(0) - (W+1)'(wy);
            end
         end
         OP_RDOWN: begin
            res_valid   = 1'b1;
            res_gesture = G_MENU;
            res_px      = x0;
            res_py      = y0;
            res_mods    = mods;
         end
         OP_DSCALE: begin
            res_valid   = 1'b1;
            res_gesture = G_SCALE;
            res_zoom    = dz;
            res_mods    = mods;
         end
         OP_DSCROLL: begin
            res_valid   = 1'b1;
            res_gesture = G_SCROLL;
            res_dx      = (W+1)'(0) - (W+1)'(wx);
            res_dy      = (W+1)'(0) - (W+1)'(wy);
            res_mods    = mods;
         end
         OP_TDOWN: begin
            down_points_in   = cnt;
            down_x_in        = x0;
            down_y_in        = y0;
            down_stamp_in    = now;
            move_x_in        = x0;
            move_y_in        = y0;
            tap_pending_in   = 1'b1;
            drag_active_in   = 1'b0;
            scroll_active_in = 1'b0;
         end
         OP_PDOWN: begin
            down_points_in = cnt;
            down_x_in      = x0;
            down_y_in      = y0;
            px0_in         = x0;
            py0_in         = y0;
            px1_in         = x1;
            py1_in         = y1;
            pmc_in         = cnt;
            if (cnt > 4'd1) begin
               pinch_in = root_w;
            end
            tap_pending_in = 1'b0;
         end
         OP_PUP: begin
            move_x_in        = x0;
            move_y_in        = y0;
            down_points_in   = 4'd1;
            down_x_in        = x0;
            down_y_in        = y0;
            pmc_in           = '0;
            tap_pending_in   = 1'b0;
            scroll_active_in = 1'b0;
            pinch_in         = '0;
         end
         OP_TMOVE: begin
            if (down_points_ff == 4'd1) begin
               if (far || drag_active_ff || scroll_active_ff) begin
                  tap_pending_in = 1'b0;
                  move_x_in      = x0;
                  move_y_in      = y0;
                  res_valid      = 1'b1;
                  if (drag_active_ff) begin
                     res_gesture = G_DRAG;
                     res_px      = x0;
                     res_py      = y0;
                  end else if (!scroll_active_ff) begin
                     scroll_active_in = 1'b1;
                     res_gesture      = G_SCROLL;
                  end else begin
                     res_gesture = G_SCROLL;
                     res_dx      = (W+1)'(move_x_ff) - (W+1)'(x0);
                     res_dy      = (W+1)'(move_y_ff) - (W+1)'(y0);
                  end
               end else if (tap_pending_ff && (dt_down > lp_ext)) begin
                  tap_pending_in = 1'b0;
                  res_valid      = 1'b1;
                  res_gesture    = G_LPRESS;
                  res_px         = down_x_ff;
                  res_py         = down_y_ff;
               end
            end else if (cnt == 4'd2) begin
               tap_pending_in = 1'b0;
               pinch_in       = root_w;
               px0_in         = x0;
               py0_in         = y0;
               px1_in         = x1;
               py1_in         = y1;
               pmc_in         = 4'd2;
               if (pinch_ff != '0) begin
                  res_valid   = 1'b1;
                  res_gesture = G_SCALE;
                  res_zoom    = zq;
               end
            end else if (cnt >= 4'd3) begin
               tap_pending_in = 1'b0;
               px0_in         = x0;
               py0_in         = y0;
               px1_in         = x1;
               py1_in         = y1;
               pmc_in         = cnt;
               // fast scroll: negated half of the summed motion, away from zero
               if ((pmc_ff >= 4'd2) && ((ax > 1) || (ay > 1))) begin
                  res_valid   = 1'b1;
                  res_gesture = G_FSCROLL;
                  if (ax > ay) begin
                     res_dx = sx[W+1] ? hx : (W+1)'(0) - hx;
                  end else begin
                     res_dy = sy[W+1] ? hy : (W+1)'(0) - hy;
                  end
               end
            end
         end
         OP_TUP: begin
            if (drag_active_ff) begin
               drag_active_in = 1'b0;
            end else if (tap_pending_ff) begin
               res_valid = 1'b1;
               res_px    = down_x_ff;
               res_py    = down_y_ff;
               if (tap_recorded_ff && (dt_tapdown <= win_ext) && near) begin
                  tap_pending_in  = 1'b0;
                  tap_recorded_in = 1'b0;
                  res_gesture     = G_DTAP;
               end else if (dt_down > lp_ext) begin
                  res_gesture = G_LPRESS;
               end else begin
                  tap_stamp_in    = down_stamp_ff;
                  tap_x_in        = down_x_ff;
                  tap_y_in        = down_y_ff;
                  tap_recorded_in = 1'b1;
                  res_gesture     = G_TAP;
               end
            end
         end
         OP_CANCEL: begin
            tap_pending_in   = 1'b0;
            button_held_in   = 1'b0;
            drag_active_in   = 1'b0;
            scroll_active_in = 1'b0;
            down_points_in   = '0;
            pmc_in           = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_pending_ff   <= 1'b0;
         button_held_ff   <= 1'b0;
         drag_active_ff   <= 1'b0;
         scroll_active_ff <= 1'b0;
         tap_recorded_ff  <= 1'b0;
         down_points_ff   <= '0;
         pmc_ff           <= '0;
         down_x_ff        <= '0;
         down_y_ff        <= '0;
         move_x_ff        <= '0;
         move_y_ff        <= '0;
         tap_x_ff         <= '0;
         tap_y_ff         <= '0;
         px0_ff           <= '0;
         py0_ff           <= '0;
         px1_ff           <= '0;
         py1_ff           <= '0;
         down_stamp_ff    <= '0;
         tap_stamp_ff     <= '0;
         pinch_ff         <= '0;
      end else if (commit) begin
         tap_pending_ff   <= tap_pending_in;
         button_held_ff   <= button_held_in;
         drag_active_ff   <= drag_active_in;
         scroll_active_ff <= scroll_active_in;
         tap_recorded_ff  <= tap_recorded_in;
         down_points_ff   <= down_points_in;
         pmc_ff           <= pmc_in;
         down_x_ff        <= down_x_in;
         down_y_ff        <= down_y_in;
         move_x_ff        <= move_x_in;
         move_y_ff        <= move_y_in;
         tap_x_ff         <= tap_x_in;
         tap_y_ff         <= tap_y_in;
         px0_ff           <= px0_in;
         py0_ff           <= py0_in;
         px1_ff           <= px1_in;
         py1_ff           <= py1_in;
         down_stamp_ff    <= down_stamp_in;
         tap_stamp_ff     <= tap_stamp_in;
         pinch_ff         <= pinch_in;
      end
   end

   // ---- result register
   logic              rsp_valid_ff;
   logic [OUT_DW-1:0] rsp_data_ff;
   logic [2:0]        rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && res_valid) begin
         rsp_user_ff <= res_gesture;
         rsp_data_ff <= OUT_DW'({res_mods, res_dy, res_dx, res_zoom, res_py, res_px});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> sv/tgr_checker.sv
`timescale 1ns / 1ps
module tgr_checker import tgr_pkg::*; #(
   parameter int COORD_BITS = TGR_COORD_BITS,
   parameter int TIME_BITS  = TGR_TIME_BITS,
   localparam int IN_DW  = ((TIME_BITS + 28 + 6 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_DW = ((4 * COORD_BITS + 26 + 7) / 8) * 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [IN_DW-1:0]     req_tdata,
   input logic [3:0]           req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [OUT_DW-1:0]    rsp_tdata,
   input logic [2:0]           rsp_tuser,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [15:0]          csr_data
);

   localparam int W = COORD_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == G_SCROLL || rsp_tuser == G_FSCROLL ||
      rsp_tuser == G_SCALE) |-> (rsp_tdata[2*W-1:0] == '0))
      else $error("scroll or scale result carries a point");

   a_zoom_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != G_SCALE) |-> (rsp_tdata[2*W +: 16] == ZOOM_ONE))
      else $error("zoom not unity outside a scale");

endmodule

bind touch_gesture_recognizer_core tgr_checker #(
   .COORD_BITS (COORD_BITS),
   .TIME_BITS  (TIME_BITS)
) u_checker (.*);
